// File: hw/rtl/time_triggered_task_dispatcher_top_defines.svh
// Assertion macros for the task dispatcher.
`ifndef TIME_TRIGGERED_TASK_DISPATCHER_TOP_DEFINES_SVH
`define TIME_TRIGGERED_TASK_DISPATCHER_TOP_DEFINES_SVH

// Checked outside reset.
`define TTD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define TTD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/ttd_pkg.sv
package ttd_pkg;

   localparam logic        OP_ADD      = 1'b0;
   localparam logic        OP_DISPATCH = 1'b1;
   localparam int          TIME_W      = 32;
   localparam int          SLOT_OUT_W  = 3;
   localparam logic [31:0] IDLE_NONE   = 32'hFFFF_FFFF;
   localparam logic [31:0] S32_MIN     = 32'h8000_0000;
   localparam logic [31:0] S32_MAX     = 32'h7FFF_FFFF;

   typedef struct packed {
      logic signed [15:0] first_delay;
      logic signed [15:0] period;
   } add_type;

   typedef struct packed {
      logic                  valid;
      logic                  found;
      logic [SLOT_OUT_W-1:0] chosen;
      logic [TIME_W-1:0]     idle;
      logic [15:0]           elapsed;
   } token_type;

endpackage

// File: hw/rtl/ttd_req_if.sv
interface ttd_req_if;
   import ttd_pkg::*;

   logic               valid;
   logic               ready;
   logic               operation;
   logic signed [15:0] first_delay;
   logic signed [15:0] task_period;
   logic [15:0]        elapsed_ms;

   modport source (output valid, operation, first_delay, task_period, elapsed_ms,
                   input ready);
   modport sink   (input valid, operation, first_delay, task_period, elapsed_ms,
                   output ready);
endinterface

// File: hw/rtl/ttd_rsp_if.sv
interface ttd_rsp_if;
   import ttd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  add_status;
   logic                  task_due;
   logic [SLOT_OUT_W-1:0] task_slot;
   logic [TIME_W-1:0]     idle_ms;

   modport source (output valid, add_status, task_due, task_slot, idle_ms,
                   input ready);
   modport sink   (input valid, add_status, task_due, task_slot, idle_ms,
                   output ready);
endinterface

// File: hw/rtl/ttd_cell.sv
module ttd_cell #(
   parameter int SLOT_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               add_we,
   input  ttd_pkg::add_type   add_data,
   input  ttd_pkg::token_type tok_prev,
   output ttd_pkg::token_type tok_next
);
   import ttd_pkg::*;

   logic signed [31:0] remaining_ff, remaining_in;
   logic signed [15:0] period_ff, period_in;
   logic               running_ff, running_in;
   token_type          token_ff, token_in;

   logic signed [32:0] diff, sum;
   logic [31:0]        rem_sub, rem_reload;
   logic               due, take;

   always_comb begin
      diff    = {remaining_ff[31], remaining_ff} - {17'b0, tok_prev.elapsed};
      rem_sub = (diff[32] != diff[31]) ? S32_MIN : diff[31:0];
      due     = rem_sub[31] || (rem_sub == '0);
      take    = due && !tok_prev.found;
      sum     = {rem_sub[31], rem_sub} + 33'(period_ff);
      if (sum[32] != sum[31]) begin
         rem_reload = sum[32] ? S32_MIN : S32_MAX;
      end else begin
         rem_reload = sum[31:0];
      end
   end

   always_comb begin
      remaining_in = remaining_ff;
      period_in    = period_ff;
      running_in   = running_ff;
      token_in     = tok_prev;
      if (tok_prev.valid && running_ff) begin
         remaining_in = take ? rem_reload : rem_sub;
         if (take) begin
            token_in.found  = 1'b1;
            token_in.chosen = SLOT_OUT_W'(SLOT_INDEX);
         end
         if (due) begin
            token_in.idle = '0;
         end else if (rem_sub < tok_prev.idle) begin
            token_in.idle = rem_sub;
         end
      end
      if (add_we) begin
         remaining_in = 32'(add_data.first_delay);
         period_in    = add_data.period;
         running_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         period_ff    <= '0;
         running_ff   <= 1'b0;
         token_ff     <= '0;
      end else begin
         remaining_ff <= remaining_in;
         period_ff    <= period_in;
         running_ff   <= running_in;
         token_ff     <= token_in;
      end
   end

   assign tok_next = token_ff;

endmodule

// File: hw/rtl/time_triggered_task_dispatcher_top.sv
// Add request: result registered in the cycle after acceptance.
// Dispatch request: a token walks the slot chain, one cell per cycle, so the
// result is registered once the token has left the last cell.
// One request at a time: an add every cycle as long as the result register is
// taken at once; no new request is taken until a dispatch result is registered.
// Synchronous active-high reset empties the table and clears the result valid flag.
module time_triggered_task_dispatcher_top #(
   parameter int TASK_SLOTS = 8
) (
   input logic      clock,
   input logic      reset,
   ttd_req_if.sink   req_chan,
   ttd_rsp_if.source rsp_chan
);
   import ttd_pkg::*;
`include "time_triggered_task_dispatcher_top_defines.svh"

   localparam int CNT_W = $clog2(TASK_SLOTS + 1);

   typedef enum logic {S_IDLE, S_BUSY} state_type;

   state_type             state_ff;
   logic [CNT_W-1:0]      next_free_ff;
   logic                  rsp_valid_ff;
   logic                  add_status_ff;
   logic                  task_due_ff;
   logic [SLOT_OUT_W-1:0] task_slot_ff;
   logic [TIME_W-1:0]     idle_ms_ff;

   token_type             head_tok;
   token_type             chain [TASK_SLOTS+1];
   logic [TASK_SLOTS-1:0] chain_valid;
   logic [TASK_SLOTS-1:0] add_we;
   add_type               add_data;
   logic                  accept, full, is_add, rsp_load;

   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_add         = (req_chan.operation == OP_ADD);
   assign full           = (next_free_ff == CNT_W'(TASK_SLOTS));
   assign rsp_load       = (accept && is_add) ||
                           ((state_ff == S_BUSY) && chain[TASK_SLOTS].valid);

   assign add_data.first_delay = req_chan.first_delay;
   assign add_data.period      = req_chan.task_period;

   always_comb begin
      head_tok.valid   = accept && (req_chan.operation == OP_DISPATCH);
      head_tok.found   = 1'b0;
      head_tok.chosen  = '0;
      head_tok.idle    = IDLE_NONE;
      head_tok.elapsed = req_chan.elapsed_ms;
   end

   assign chain[0] = head_tok;

   for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
      assign add_we[i]      = accept && is_add && (next_free_ff == CNT_W'(i));
      assign chain_valid[i] = chain[i+1].valid;
      ttd_cell #(.SLOT_INDEX(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .add_we   (add_we[i]),
         .add_data (add_data),
         .tok_prev (chain[i]),
         .tok_next (chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (is_add) begin
                     add_status_ff <= full;
                     task_due_ff   <= 1'b0;
                     task_slot_ff  <= '0;
                     idle_ms_ff    <= '0;
                     if (!full) begin
                        next_free_ff <= next_free_ff + 1'b1;
                     end
                  end else begin
                     state_ff <= S_BUSY;
                  end
               end
            end
            S_BUSY: begin
               if (chain[TASK_SLOTS].valid) begin
                  add_status_ff <= 1'b0;
                  task_due_ff   <= chain[TASK_SLOTS].found;
                  task_slot_ff  <= chain[TASK_SLOTS].found ? chain[TASK_SLOTS].chosen : '0;
                  idle_ms_ff    <= chain[TASK_SLOTS].idle;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.add_status = add_status_ff;
   assign rsp_chan.task_due   = task_due_ff;
   assign rsp_chan.task_slot  = task_slot_ff;
   assign rsp_chan.idle_ms    = idle_ms_ff;

   `TTD_ASSERT(a_one_token, $countones(chain_valid) <= 1, "more than one token in chain")
   `TTD_ASSERT(a_done_busy, chain[TASK_SLOTS].valid |-> state_ff == S_BUSY, "token out while idle")
   `TTD_ASSERT(a_rsp_free, chain[TASK_SLOTS].valid |-> !rsp_valid_ff, "result register busy")
   `TTD_ASSERT_ALWAYS(a_fill, reset || (next_free_ff <= CNT_W'(TASK_SLOTS)), "fill count past table size")

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ttd_pkg::*;

   localparam int TASK_SLOTS    = 8;
   localparam int SETTLE_CYCLES = TASK_SLOTS + 8;

   typedef struct packed {
      logic                  add_status;
      logic                  task_due;
      logic [SLOT_OUT_W-1:0] task_slot;
      logic [TIME_W-1:0]     idle_ms;
   } schedule_outcome_type;

   logic clock = 1'b0;
   logic reset;
   int   failures         = 0;
   int   req_idle_pct     = 0;
   int   rsp_idle_pct     = 0;
   int   rsp_hold_request = 0;

   logic signed [31:0]   slot_remaining [TASK_SLOTS];
   logic signed [15:0]   slot_period    [TASK_SLOTS];
   logic                 slot_active    [TASK_SLOTS];
   int                   slots_filled;
   schedule_outcome_type pending_outcomes [$];
   schedule_outcome_type oldest;

   ttd_req_if req_chan ();
   ttd_rsp_if rsp_chan ();

   time_triggered_task_dispatcher_top #(.TASK_SLOTS(TASK_SLOTS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #2 clock = ~clock;

   function automatic logic signed [31:0] clamp_add(logic signed [31:0] a,
                                                    logic signed [31:0] b);
      logic [32:0] sum;
      sum = {a[31], a} + {b[31], b};
      if (sum[32] != sum[31]) begin
         return sum[32] ? S32_MIN : S32_MAX;
      end
      return sum[31:0];
   endfunction

   function automatic schedule_outcome_type schedule_step(logic op,
                                                          logic signed [15:0] delay,
                                                          logic signed [15:0] period,
                                                          logic [15:0] elapsed);
      schedule_outcome_type res;
      logic signed [31:0]   elapsed_s;
      res = '0;
      if (op == OP_ADD) begin
         if (slots_filled < TASK_SLOTS) begin
            slot_remaining[slots_filled] = delay;
            slot_period[slots_filled]    = period;
            slot_active[slots_filled]    = 1'b1;
            slots_filled++;
         end else begin
            res.add_status = 1'b1;
         end
         return res;
      end
      elapsed_s   = {16'd0, elapsed};
      res.idle_ms = IDLE_NONE;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         if (slot_active[i]) begin
            slot_remaining[i] = clamp_add(slot_remaining[i], -elapsed_s);
            if (slot_remaining[i] <= 0) begin
               if (!res.task_due) begin
                  res.task_due      = 1'b1;
                  res.task_slot     = SLOT_OUT_W'(i);
                  slot_remaining[i] = clamp_add(slot_remaining[i], slot_period[i]);
               end
               res.idle_ms = '0;
            end else if ($unsigned(slot_remaining[i]) < res.idle_ms) begin
               res.idle_ms = $unsigned(slot_remaining[i]);
            end
         end
      end
      return res;
   endfunction

   function automatic logic [15:0] pick_elapsed();
      int roll;
      int ms;
      roll = $urandom_range(99);
      if (roll < 90) begin
         ms = $urandom_range(30);
      end else if (roll < 99) begin
         ms = $urandom_range(200, 31);
      end else begin
         ms = $urandom_range(1500, 201);
      end
      // slot 0 has a negative period; once due it would stay due for good
      if (ms + 1000 >= slot_remaining[0]) begin
         ms = 0;
      end
      return 16'(ms);
   endfunction

   task automatic send_request(input logic op, input logic [15:0] delay, period, elapsed);
      while ($urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid       <= 1'b1;
      req_chan.operation   <= op;
      req_chan.first_delay <= delay;
      req_chan.task_period <= period;
      req_chan.elapsed_ms  <= elapsed;
      do @(posedge clock); while (!req_chan.ready);
      pending_outcomes.push_back(schedule_step(op, delay, period, elapsed));
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_table();
      send_request(OP_DISPATCH, 16'h0000, 16'h0000, 16'h0000);
      send_request(OP_DISPATCH, 16'h8000, 16'h7FFF, 16'hFFFF);
   endtask

   task automatic test_add_extremes();
      send_request(OP_ADD, 16'h7FFF, 16'h8000, 16'h0000);
      send_request(OP_ADD, 16'h8000, 16'h7FFF, 16'hFFFF);
      send_request(OP_DISPATCH, 16'h0000, 16'h0000, 16'd0);
      send_request(OP_DISPATCH, 16'h5555, 16'hAAAA, 16'd0);
      send_request(OP_DISPATCH, 16'hAAAA, 16'h5555, 16'd1);
   endtask

   task automatic test_random_schedule(input int count);
      logic        op;
      logic [15:0] delay, period, elapsed;
      repeat (count) begin
         op      = OP_DISPATCH;
         delay   = 16'($urandom);
         period  = 16'($urandom);
         elapsed = pick_elapsed();
         // last slot is kept for the zero-period task
         if (slots_filled < TASK_SLOTS - 1 && $urandom_range(24) == 0) begin
            op      = OP_ADD;
            delay   = 16'($urandom_range(2200)) - 16'd200;
            period  = 16'($urandom_range(2000, 40));
            elapsed = 16'($urandom);
         end
         send_request(op, delay, period, elapsed);
      end
   endtask

   task automatic test_backpressure();
      wait_all_results();
      rsp_hold_request = 80;
      repeat (12) begin
         send_request(OP_DISPATCH, 16'($urandom), 16'($urandom), pick_elapsed());
      end
      wait_all_results();
   endtask

   task automatic test_degenerate_tasks();
      send_request(OP_ADD, 16'h0000, 16'h0000, 16'hFFFF);
      send_request(OP_ADD, 16'h7FFF, 16'h7FFF, 16'h0000);
      send_request(OP_ADD, 16'h8000, 16'h8000, 16'hFFFF);
      send_request(OP_DISPATCH, 16'hFFFF, 16'h0000, 16'h0000);
      send_request(OP_DISPATCH, 16'h0000, 16'hFFFF, 16'h0001);
      // full-scale ticks keep slot 0 due under its negative period
      for (int sent = 0; sent < 60; sent++) begin
         if (sent % 16 == 15) begin
            send_request(OP_ADD, 16'($urandom), 16'($urandom), 16'($urandom));
         end else begin
            send_request(OP_DISPATCH, 16'($urandom), 16'($urandom), 16'hFFFF);
         end
      end
   endtask

   initial begin
      int hold_left;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result: idle_ms %0h", rsp_chan.idle_ms);
            failures++;
         end else begin
            oldest = pending_outcomes.pop_front();
            if (rsp_chan.add_status !== oldest.add_status) begin
               $error("add_status: expected %0d, got %0d", oldest.add_status,
                      rsp_chan.add_status);
               failures++;
            end
            if (rsp_chan.task_due !== oldest.task_due) begin
               $error("task_due: expected %0d, got %0d", oldest.task_due,
                      rsp_chan.task_due);
               failures++;
            end
            if (rsp_chan.task_slot !== oldest.task_slot) begin
               $error("task_slot: expected %0d, got %0d", oldest.task_slot,
                      rsp_chan.task_slot);
               failures++;
            end
            if (rsp_chan.idle_ms !== oldest.idle_ms) begin
               $error("idle_ms: expected %0h, got %0h", oldest.idle_ms,
                      rsp_chan.idle_ms);
               failures++;
            end
         end
      end
   end

   initial begin
      #12ms;
      $display("FAILURE");
      $finish;
   end

   initial begin
      foreach (slot_remaining[i]) begin
         slot_remaining[i] = '0;
         slot_period[i]    = '0;
         slot_active[i]    = 1'b0;
      end
      slots_filled         = 0;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.operation   = OP_ADD;
      req_chan.first_delay = '0;
      req_chan.task_period = '0;
      req_chan.elapsed_ms  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 17;
      rsp_idle_pct = 75;
      test_empty_table();
      test_add_extremes();
      test_random_schedule(400);
      req_idle_pct = 75;
      rsp_idle_pct = 17;
      test_random_schedule(400);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_schedule(400);
      test_backpressure();
      test_degenerate_tasks();
      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
